### design/irc_pkg.sv
package irc_pkg;

  // field widths
  localparam int CH_W      = 3;
  localparam int ADC_W     = 12;
  localparam int DT_W      = 16;
  localparam int TAU_W     = 20;
  localparam int THR_W     = 12;
  localparam int LEVEL_W   = 20;
  localparam int DIST_W    = 19;
  localparam int COEFF_W   = 64;
  localparam int GAIN_BITS = 16;

  // sensor and fixed-point format
  localparam int NUM_CHANNELS    = 5;
  localparam int ADC_BITS        = 12;
  localparam int LEVEL_FRAC_BITS = 8;

  // only the low ADC_BITS of a sample count, never more than the field
  localparam logic [ADC_W-1:0] ADC_MASK =
    (ADC_BITS >= ADC_W) ? {ADC_W{1'b1}} : ADC_W'((1 << ADC_BITS) - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

  // 0.95 in Q0.16
  localparam logic [GAIN_BITS-1:0] DECAY_Q16 = 16'd62259;

  // distance clamp in um
  localparam int DIST_MIN = 30000;
  localparam int DIST_MAX = 400000;

  // register file
  localparam int CFG_IDX_W  = 3;
  localparam int COEFF_REGS = 5;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 64'h4E20_0000_4786_8C00;
  localparam logic [TAU_W-1:0]   TAU_RESET   = 20'd20000;
  localparam logic [THR_W-1:0]   PRES_RESET  = 12'd40;
  localparam logic [THR_W-1:0]   SAT_RESET   = 12'd3500;

  localparam logic [CFG_IDX_W-1:0] CFG_TAU  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT  = 3'd7;

  // stream widths
  localparam int IN_DATA_W  = ((2 * ADC_W + DT_W + 7) / 8) * 8;
  localparam int IN_USER_W  = CH_W + 1;
  localparam int OUT_DATA_W = ((LEVEL_W + DIST_W + 2 + 7) / 8) * 8;
  localparam int OUT_USER_W = CH_W;

endpackage

### design/ir_range_sensor_conditioner_top.sv
// requests are taken one at a time: a new request is accepted only once the last result
//   has gone to the output stage; a channel beyond the level store skips both units
// each result is set by the 16-step gain divide/multiply (skipped with full gain) and
//   the 19-step distance divide, one bit per cycle
// reset: synchronous active low; clears all channel levels, loads register defaults
//   and empties the output stage
module ir_range_sensor_conditioner_top #(
  parameter int NUM_CHANNELS = irc_pkg::NUM_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [irc_pkg::IN_DATA_W-1:0]     in_tdata,   // sample_off, sample_on, dt_us
  input  logic [irc_pkg::IN_USER_W-1:0]     in_tuser,   // channel, channel_exists
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [irc_pkg::OUT_DATA_W-1:0]    out_tdata,  // filtered_level, distance_um,
                                                        // wall_present, saturated, zero pad
  output logic [irc_pkg::OUT_USER_W-1:0]    out_tuser,  // channel_out
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [irc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irc_pkg::COEFF_W-1:0]       cfg_data
);

  localparam int CH_W  = irc_pkg::CH_W;
  localparam int LW    = irc_pkg::LEVEL_W;
  localparam int DW    = irc_pkg::DIST_W;
  localparam int ADC_W = irc_pkg::ADC_W;
  localparam int F     = irc_pkg::LEVEL_FRAC_BITS;
  localparam int ST_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CMP_W = (irc_pkg::THR_W + F > LW) ? irc_pkg::THR_W + F : LW;

  typedef enum logic [1:0] {S_IDLE, S_LEVEL, S_DIST, S_DONE} state_t;

  state_t                        state_r;
  logic [CH_W-1:0]               ch_r;
  logic                          exists_r;
  logic [LW-1:0]                 res_level_r;
  logic [DW-1:0]                 res_dist_r;
  logic                          res_pres_r;
  logic                          res_sat_r;
  logic                          out_tvalid_r;
  logic [irc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [CH_W-1:0]               out_user_r;

  logic [LW-1:0]                 level_store_r [NUM_CHANNELS];
  logic [irc_pkg::COEFF_W-1:0]   coeff_r [irc_pkg::COEFF_REGS];
  logic [irc_pkg::TAU_W-1:0]     tau_r;
  logic [irc_pkg::THR_W-1:0]     pres_thr_r;
  logic [irc_pkg::THR_W-1:0]     sat_thr_r;

  logic [CH_W-1:0]               in_channel;
  logic                          in_exists;
  logic [ADC_W-1:0]              in_off, in_on;
  logic [irc_pkg::DT_W-1:0]      in_dt;
  logic                          in_accept;
  logic                          in_range;
  logic                          lvl_start, lvl_done;
  logic [LW-1:0]                 lvl_out;
  logic                          dist_start, dist_done;
  logic [DW-1:0]                 dist_out;
  logic [irc_pkg::COEFF_W-1:0]   coeff_sel;
  logic                          pres_hit, sat_hit;

  // unpack the input request
  always_comb begin
    in_channel = in_tuser[CH_W-1:0];
    in_exists  = in_tuser[CH_W];
    in_off     = in_tdata[ADC_W-1:0];
    in_on      = in_tdata[2*ADC_W-1:ADC_W];
    in_dt      = in_tdata[2*ADC_W +: irc_pkg::DT_W];
    in_accept  = in_tvalid && in_tready;
    in_range   = int'(in_channel) < NUM_CHANNELS;
    lvl_start  = in_accept && in_range;
    dist_start = (state_r == S_LEVEL) && lvl_done;
  end

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // coefficient pick; channels past the register file use the default
  assign coeff_sel = (int'(ch_r) < irc_pkg::COEFF_REGS) ? coeff_r[ch_r] : irc_pkg::COEFF_RESET;

  // level thresholds
  always_comb begin
    pres_hit = CMP_W'(lvl_out) > (CMP_W'(pres_thr_r) << F);
    sat_hit  = CMP_W'(lvl_out) > (CMP_W'(sat_thr_r) << F);
  end

  irc_level_unit u_level (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (lvl_start),
    .exists     (in_exists),
    .sample_off (in_off),
    .sample_on  (in_on),
    .dt_us      (in_dt),
    .tau        (tau_r),
    .level_in   (level_store_r[ST_W'(in_channel)]),
    .done       (lvl_done),
    .level_out  (lvl_out)
  );

  irc_dist_unit u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dist_start),
    .level_in (lvl_out),
    .coeff    (coeff_sel),
    .done     (dist_done),
    .dist_out (dist_out)
  );

  // register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < irc_pkg::COEFF_REGS; i++) begin
        coeff_r[i] <= irc_pkg::COEFF_RESET;
      end
      tau_r      <= irc_pkg::TAU_RESET;
      pres_thr_r <= irc_pkg::PRES_RESET;
      sat_thr_r  <= irc_pkg::SAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        irc_pkg::CFG_TAU:  tau_r      <= cfg_data[irc_pkg::TAU_W-1:0];
        irc_pkg::CFG_PRES: pres_thr_r <= cfg_data[irc_pkg::THR_W-1:0];
        irc_pkg::CFG_SAT:  sat_thr_r  <= cfg_data[irc_pkg::THR_W-1:0];
        default: begin
          if (int'(cfg_index) < irc_pkg::COEFF_REGS) begin
            coeff_r[cfg_index] <= cfg_data;
          end
        end
      endcase
    end
  end

  // per-channel filter levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        level_store_r[i] <= '0;
      end
    end else if (dist_start) begin
      level_store_r[ST_W'(ch_r)] <= lvl_out;
    end
  end

  // request sequencing and output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      // the result stage reloads the slot itself when it frees up
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            ch_r     <= in_channel;
            exists_r <= in_exists;
            if (in_range) begin
              state_r <= S_LEVEL;
            end else begin
              res_level_r <= '0;
              res_dist_r  <= DW'(irc_pkg::DIST_MAX);
              res_pres_r  <= 1'b0;
              res_sat_r   <= 1'b0;
              state_r     <= S_DONE;
            end
          end
        end
        S_LEVEL: begin
          if (lvl_done) begin
            res_level_r <= lvl_out;
            res_pres_r  <= exists_r && pres_hit;
            res_sat_r   <= sat_hit;
            state_r     <= S_DIST;
          end
        end
        S_DIST: begin
          if (dist_done) begin
            res_dist_r <= dist_out;
            state_r    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= irc_pkg::OUT_DATA_W'({res_sat_r, res_pres_r, res_dist_r, res_level_r});
            out_user_r   <= ch_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### design/irc_level_unit.sv
module irc_level_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              exists,
  input  logic [irc_pkg::ADC_W-1:0]         sample_off,
  input  logic [irc_pkg::ADC_W-1:0]         sample_on,
  input  logic [irc_pkg::DT_W-1:0]          dt_us,
  input  logic [irc_pkg::TAU_W-1:0]         tau,
  input  logic [irc_pkg::LEVEL_W-1:0]       level_in,
  output logic                              done,
  output logic [irc_pkg::LEVEL_W-1:0]       level_out
);

  localparam int LW = irc_pkg::LEVEL_W;
  localparam int GB = irc_pkg::GAIN_BITS;
  localparam int TW = irc_pkg::TAU_W;
  localparam int F  = irc_pkg::LEVEL_FRAC_BITS;
  localparam int AW = LW + GB + 2;
  localparam int CW = $clog2(GB);
  localparam int XW = (irc_pkg::ADC_W + F > LW) ? irc_pkg::ADC_W + F : LW;
  localparam int HALF = 1 << (GB - 1);

  typedef enum logic [1:0] {L_IDLE, L_RUN, L_FIN} state_t;

  state_t                 state_r;
  logic [CW-1:0]          cnt_r;
  logic signed [AW-1:0]   acc_r;
  logic signed [LW:0]     op_r;
  logic [LW-1:0]          base_r;
  logic                   rnd_r;
  logic                   div_r;
  logic [TW:0]            rem_r;
  logic [GB-1:0]          dec_sr_r;
  logic [LW-1:0]          level_r;
  logic                   done_r;

  logic [irc_pkg::ADC_W-1:0] on_m, off_m, amb_diff;
  logic [XW-1:0]          x_wide;
  logic [LW-1:0]          x_val;
  logic                   gain_one;
  logic [TW:0]            step_t;
  logic                   div_ge, bit_q;
  logic [TW:0]            rem_nxt;
  logic signed [AW-1:0]   acc_nxt;
  logic signed [AW-1:0]   sum_v, shifted;
  logic [LW-1:0]          level_nxt;

  // ambient subtraction and scaling into the level format
  always_comb begin
    on_m     = sample_on & irc_pkg::ADC_MASK;
    off_m    = sample_off & irc_pkg::ADC_MASK;
    amb_diff = (on_m > off_m) ? on_m - off_m : '0;
    x_wide   = XW'(amb_diff) << F;
    x_val    = (x_wide > XW'(irc_pkg::LEVEL_MAX)) ? irc_pkg::LEVEL_MAX : LW'(x_wide);
    gain_one = TW'(dt_us) >= tau;
  end

  // one gain bit per cycle: restoring divide of dt/tau, or the decay constant,
  // feeding an msb-first shift-add multiply
  always_comb begin
    step_t  = {rem_r[TW-1:0], 1'b0};
    div_ge  = step_t >= {1'b0, tau};
    bit_q   = div_r ? div_ge : dec_sr_r[GB-1];
    rem_nxt = (div_r && div_ge) ? step_t - {1'b0, tau} : step_t;
    acc_nxt = (acc_r <<< 1) + (bit_q ? AW'(op_r) : '0);
  end

  // rounding for fitted channels, rescale and add the base level (old level on a step update, else zero)
  always_comb begin
    sum_v     = acc_r + (rnd_r ? AW'(HALF) : '0);
    shifted   = sum_v >>> GB;
    level_nxt = LW'(shifted) + base_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == L_FIN);
      unique case (state_r)
        L_IDLE: begin
          if (start) begin
            rem_r    <= (TW+1)'(dt_us);
            dec_sr_r <= irc_pkg::DECAY_Q16;
            cnt_r    <= CW'(GB - 1);
            div_r    <= exists;
            rnd_r    <= exists;
            if (exists && gain_one) begin
              // level takes the sample outright
              acc_r   <= AW'(x_val) << GB;
              op_r    <= '0;
              base_r  <= '0;
              state_r <= L_FIN;
            end else if (exists) begin
              acc_r   <= '0;
              op_r    <= $signed({1'b0, x_val}) - $signed({1'b0, level_in});
              base_r  <= level_in;
              state_r <= L_RUN;
            end else begin
              acc_r   <= '0;
              op_r    <= $signed({1'b0, level_in});
              base_r  <= '0;
              state_r <= L_RUN;
            end
          end
        end
        L_RUN: begin
          acc_r    <= acc_nxt;
          rem_r    <= rem_nxt;
          dec_sr_r <= dec_sr_r << 1;
          cnt_r    <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= L_FIN;
          end
        end
        L_FIN: begin
          level_r <= level_nxt;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done      = done_r;
  assign level_out = level_r;

endmodule

### design/irc_dist_unit.sv
module irc_dist_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [irc_pkg::LEVEL_W-1:0]       level_in,
  input  logic [irc_pkg::COEFF_W-1:0]       coeff,
  output logic                              done,
  output logic [irc_pkg::DIST_W-1:0]        dist_out
);

  localparam int F     = irc_pkg::LEVEL_FRAC_BITS;
  localparam int LW    = irc_pkg::LEVEL_W;
  localparam int DEN_W = ((LW > 15 + F) ? LW : 15 + F) + 1;
  localparam int DS_W  = DEN_W + 1;
  localparam int DIV_W = 32 + F;
  localparam int QB    = irc_pkg::DIST_W;
  localparam int CMP_W = DEN_W + QB;
  localparam int SUM_W = QB + 2;
  localparam int CW    = $clog2(QB);
  localparam int ONE   = 1 << F;

  typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN, D_FIN} state_t;

  state_t               state_r;
  logic [31:0]          a_r;
  logic signed [15:0]   c_r;
  logic [DEN_W-1:0]     denom_r;
  logic                 ovf_r;
  logic [DEN_W-1:0]     rem_r;
  logic [QB-1:0]        sr_r;
  logic [QB-1:0]        q_r;
  logic [CW-1:0]        cnt_r;
  logic [QB-1:0]        dist_r;
  logic                 done_r;

  logic signed [15:0]   coef_b;
  logic signed [DS_W-1:0] lvl_s, b_s, den_s;
  logic [DEN_W-1:0]     den_v;
  logic [DIV_W-1:0]     dvd;
  logic                 ovf_v;
  logic [DEN_W:0]       step_t;
  logic                 ge;
  logic [DEN_W-1:0]     rem_nxt;
  logic signed [SUM_W-1:0] sum_v;
  logic [QB-1:0]        dist_v;

  // denominator level - b, floored at one count
  always_comb begin
    coef_b = $signed(coeff[47:32]);
    lvl_s  = $signed(DS_W'(level_in));
    b_s    = DS_W'(coef_b);
    den_s  = lvl_s - (b_s <<< F);
    den_v  = (den_s < DS_W'(ONE)) ? DEN_W'(ONE) : DEN_W'(den_s);
  end

  // quotient that does not fit the 19-bit divider is caught up front
  always_comb begin
    dvd   = {a_r, {F{1'b0}}};
    ovf_v = CMP_W'(dvd) >= (CMP_W'(denom_r) << QB);
  end

  // restoring divide step, dividend bits shifted in msb first
  always_comb begin
    step_t  = {rem_r, sr_r[QB-1]};
    ge      = step_t >= {1'b0, denom_r};
    rem_nxt = ge ? DEN_W'(step_t - {1'b0, denom_r}) : DEN_W'(step_t);
  end

  // offset and clamp
  always_comb begin
    sum_v = $signed({2'b00, q_r}) + SUM_W'(c_r);
    if (ovf_r || sum_v > irc_pkg::DIST_MAX) begin
      dist_v = QB'(irc_pkg::DIST_MAX);
    end else if (sum_v < irc_pkg::DIST_MIN) begin
      dist_v = QB'(irc_pkg::DIST_MIN);
    end else begin
      dist_v = QB'(sum_v);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == D_FIN);
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            a_r     <= coeff[31:0];
            c_r     <= $signed(coeff[63:48]);
            denom_r <= den_v;
            state_r <= D_CHK;
          end
        end
        D_CHK: begin
          ovf_r   <= ovf_v;
          rem_r   <= DEN_W'(dvd >> QB);
          sr_r    <= dvd[QB-1:0];
          q_r     <= '0;
          cnt_r   <= CW'(QB - 1);
          state_r <= D_RUN;
        end
        D_RUN: begin
          rem_r <= rem_nxt;
          sr_r  <= sr_r << 1;
          q_r   <= {q_r[QB-2:0], ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= D_FIN;
          end
        end
        D_FIN: begin
          dist_r  <= dist_v;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign dist_out = dist_r;

endmodule

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import irc_pkg::*;

  localparam int CLK_HALF      = 1;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 45;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 400;
  localparam int ITEMS_PER_SET = 100;

  // first coefficient register, channel i sits at this index plus i
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF0 = 3'd0;
  localparam logic [63:0] GAIN_ONE = 64'd65536;
  localparam logic [63:0] ROUND_HALF = 64'd32768;

  // result field positions in out_tdata
  localparam int LVL_LSB  = 0;
  localparam int DIST_LSB = LEVEL_W;
  localparam int PRES_BIT = LEVEL_W + DIST_W;
  localparam int SAT_BIT  = PRES_BIT + 1;

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [LEVEL_W-1:0] level;
    logic [DIST_W-1:0]  distance;
    logic               present;
    logic               sat;
  } range_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic [IN_USER_W-1:0]   in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [OUT_USER_W-1:0]  out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [COEFF_W-1:0]     cfg_data = '0;

  // predictor state and register copy
  logic [LEVEL_W-1:0] level_mem [NUM_CHANNELS];
  logic [COEFF_W-1:0] coeff_mem [COEFF_REGS];
  logic [TAU_W-1:0]   tau_us;
  logic [THR_W-1:0]   pres_thr;
  logic [THR_W-1:0]   sat_thr;

  range_result_t pending_ranges [$];
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  int            send_idle_pct = 23;
  int            recv_idle_pct = 80;

  ir_range_sensor_conditioner_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // stall watchdog: any handshake on input, output or config restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[ir_range_sensor_conditioner_top] ERROR");
        $finish;
      end
    end
  end

  // expected result for one reading, advances the channel level
  function automatic range_result_t condition_reading(input logic [CH_W-1:0] ch,
                                                      input logic fitted,
                                                      input logic [ADC_W-1:0] off,
                                                      input logic [ADC_W-1:0] on,
                                                      input logic [DT_W-1:0] dt);
    range_result_t r;
    logic [63:0] lvl, gain, x, span, k, off_m, on_m;
    longint one, b, c, denom, numer, d;
    r.channel = ch;
    if (ch >= NUM_CHANNELS) begin
      r.level = '0;
      r.distance = DIST_W'(DIST_MAX);
      r.present = 1'b0;
      r.sat = 1'b0;
      return r;
    end
    lvl = 64'(level_mem[ch]);
    if (fitted) begin
      off_m = 64'(off & ADC_MASK);
      on_m = 64'(on & ADC_MASK);
      span = (on_m > off_m) ? on_m - off_m : 64'd0;
      x = span << LEVEL_FRAC_BITS;
      if (x > 64'(LEVEL_MAX)) x = 64'(LEVEL_MAX);
      if (tau_us == '0) begin
        gain = GAIN_ONE;
      end else begin
        gain = (64'(dt) << 16) / 64'(tau_us);
        if (gain > GAIN_ONE) gain = GAIN_ONE;
      end
      lvl = (lvl * (GAIN_ONE - gain) + x * gain + ROUND_HALF) >> 16;
    end else begin
      lvl = (lvl * 64'(DECAY_Q16)) >> 16;
    end
    lvl = lvl & 64'(LEVEL_MAX);
    level_mem[ch] = lvl[LEVEL_W-1:0];

    // distance from a, b, c of this channel
    k = (ch < COEFF_REGS) ? coeff_mem[ch] : COEFF_RESET;
    one = longint'(1) << LEVEL_FRAC_BITS;
    b = longint'(signed'(k[47:32]));
    c = longint'(signed'(k[63:48]));
    denom = longint'(lvl) - b * one;
    if (denom < one) denom = one;
    numer = longint'({32'd0, k[31:0]}) << LEVEL_FRAC_BITS;
    d = numer / denom + c;
    if (d < DIST_MIN) d = DIST_MIN;
    if (d > DIST_MAX) d = DIST_MAX;

    r.level = lvl[LEVEL_W-1:0];
    r.distance = DIST_W'(d);
    r.present = fitted && (lvl > (64'(pres_thr) << LEVEL_FRAC_BITS));
    r.sat = lvl > (64'(sat_thr) << LEVEL_FRAC_BITS);
    return r;
  endfunction

  function automatic logic [COEFF_W-1:0] pack_coeff(input logic [31:0] a,
                                                    input logic [15:0] b,
                                                    input logic [15:0] c);
    return {c, b, a};
  endfunction

  // result checker
  always @(posedge clk) begin
    range_result_t want, seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen.channel = out_tuser[CH_W-1:0];
      seen.level = out_tdata[LVL_LSB +: LEVEL_W];
      seen.distance = out_tdata[DIST_LSB +: DIST_W];
      seen.present = out_tdata[PRES_BIT];
      seen.sat = out_tdata[SAT_BIT];
      if (pending_ranges.size() == 0) begin
        $display("%0t unexpected result ch %0d level %0d dist %0d", $time,
                 seen.channel, seen.level, seen.distance);
        mismatch_count++;
      end else begin
        want = pending_ranges.pop_front();
        if (seen.channel !== want.channel) begin
          $display("%0t channel_out exp %0d got %0d", $time, want.channel, seen.channel);
          mismatch_count++;
        end
        if (seen.level !== want.level) begin
          $display("%0t ch %0d filtered_level exp %0d got %0d", $time, want.channel,
                   want.level, seen.level);
          mismatch_count++;
        end
        if (seen.distance !== want.distance) begin
          $display("%0t ch %0d distance_um exp %0d got %0d", $time, want.channel,
                   want.distance, seen.distance);
          mismatch_count++;
        end
        if (seen.present !== want.present) begin
          $display("%0t ch %0d wall_present exp %0b got %0b", $time, want.channel,
                   want.present, seen.present);
          mismatch_count++;
        end
        if (seen.sat !== want.sat) begin
          $display("%0t ch %0d saturated exp %0b got %0b", $time, want.channel,
                   want.sat, seen.sat);
          mismatch_count++;
        end
      end
    end
  end

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < NUM_CHANNELS; i++) level_mem[i] = '0;
    for (int i = 0; i < COEFF_REGS; i++) coeff_mem[i] = COEFF_RESET;
    tau_us = TAU_RESET;
    pres_thr = PRES_RESET;
    sat_thr = SAT_RESET;
    @(posedge clk);
  endtask

  // one reading request, with a random gap ahead of it
  task automatic send_reading(input logic [CH_W-1:0] ch, input logic fitted,
                              input logic [ADC_W-1:0] off, input logic [ADC_W-1:0] on,
                              input logic [DT_W-1:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'({dt, on, off});
    in_tuser <= {fitted, ch};
    do @(posedge clk); while (!in_tready);
    pending_ranges.push_back(condition_reading(ch, fitted, off, on, dt));
  endtask

  // register write, copy updated on acceptance
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [COEFF_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < COEFF_REGS) begin
      coeff_mem[idx] = value;
    end else begin
      case (idx)
        CFG_TAU:  tau_us = value[TAU_W-1:0];
        CFG_PRES: pres_thr = value[THR_W-1:0];
        CFG_SAT:  sat_thr = value[THR_W-1:0];
        default: ;
      endcase
    end
    @(posedge clk);
  endtask

  // hold off until every result is back and the block has gone quiet
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic randomize_registers();
    logic [31:0] a;
    logic [15:0] b, c;
    logic [TAU_W-1:0] tau;
    for (int i = 0; i < COEFF_REGS; i++) begin
      a = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2000000000, 100000000);
      b = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(60)) - 16'd30;
      c = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40000)) - 16'd20000;
      write_register(CFG_COEFF0 + CFG_IDX_W'(i), pack_coeff(a, b, c));
    end
    case ($urandom_range(5))
      0: tau = '0;
      1: tau = 20'd1;
      2: tau = 20'd1000000;
      3: tau = 20'($urandom);
      default: tau = 20'($urandom_range(40000, 200));
    endcase
    write_register(CFG_TAU, COEFF_W'(tau));
    write_register(CFG_PRES, ($urandom_range(3) == 0) ? COEFF_W'(12'($urandom)) :
                                                       COEFF_W'($urandom_range(300)));
    write_register(CFG_SAT, ($urandom_range(3) == 0) ? COEFF_W'(12'($urandom)) :
                                                      COEFF_W'($urandom_range(4095, 1500)));
  endtask

  // mostly fitted in-range channels so levels build up over many updates
  task automatic send_random_reading();
    logic [CH_W-1:0] ch;
    logic fitted;
    logic [ADC_W-1:0] off, on;
    logic [DT_W-1:0] dt;
    ch = ($urandom_range(99) < 10) ? CH_W'($urandom_range(7, 5)) : CH_W'($urandom_range(4));
    fitted = ($urandom_range(99) < 85);
    case ($urandom_range(3))
      0: begin
        off = 12'($urandom);
        on = 12'($urandom);
      end
      1: begin
        off = 12'($urandom_range(300));
        on = 12'($urandom_range(4095, 2500));
      end
      2: begin
        off = 12'($urandom_range(300));
        on = 12'($urandom_range(600));
      end
      default: begin
        off = 12'($urandom);
        on = 12'($urandom_range(4095));
      end
    endcase
    case ($urandom_range(9))
      0: dt = '0;
      1: dt = 16'hFFFF;
      2, 3: dt = 16'($urandom);
      default: dt = 16'($urandom_range(2000));
    endcase
    send_reading(ch, fitted, off, on, dt);
  endtask

  // sample extremes with reset settings
  task automatic test_sample_extremes();
    send_reading(3'd0, 1'b1, 12'd0, 12'd4095, 16'hFFFF);
    send_reading(3'd0, 1'b1, 12'd4095, 12'd0, 16'hFFFF);
    send_reading(3'd1, 1'b1, 12'd100, 12'd4095, 16'd1000);
    send_reading(3'd1, 1'b1, 12'd0, 12'd0, 16'd0);
    send_reading(3'd2, 1'b1, 12'hAAA, 12'h555, 16'hAAAA);
    send_reading(3'd2, 1'b1, 12'h555, 12'hAAA, 16'h5555);
  endtask

  // unfitted channel decays its level, still flags saturation
  task automatic test_unfitted_decay();
    send_reading(3'd0, 1'b1, 12'd0, 12'd4095, 16'hFFFF);
    send_reading(3'd0, 1'b0, 12'd0, 12'd4095, 16'hFFFF);
    send_reading(3'd0, 1'b0, 12'hFFF, 12'd0, 16'd0);
  endtask

  // channels past the level store
  task automatic test_out_of_range_channels();
    send_reading(3'd5, 1'b1, 12'd0, 12'd4095, 16'hFFFF);
    send_reading(3'd6, 1'b0, 12'hFFF, 12'hFFF, 16'd0);
    send_reading(3'd7, 1'b1, 12'd10, 12'd2000, 16'd500);
  endtask

  // zero, unit and extreme time constants
  task automatic test_time_constant();
    settle_block();
    write_register(CFG_TAU, COEFF_W'(0));
    send_reading(3'd4, 1'b1, 12'd0, 12'd3000, 16'd0);
    settle_block();
    write_register(CFG_TAU, COEFF_W'(1));
    send_reading(3'd4, 1'b1, 12'd0, 12'd1000, 16'd1);
    settle_block();
    write_register(CFG_TAU, COEFF_W'(20'hFFFFF));
    send_reading(3'd4, 1'b1, 12'd0, 12'd4095, 16'hFFFF);
    settle_block();
    write_register(CFG_TAU, COEFF_W'(1000000));
    send_reading(3'd4, 1'b1, 12'd0, 12'd4095, 16'hFFFF);
  endtask

  // thresholds at zero, at full scale and on the boundary
  task automatic test_thresholds();
    settle_block();
    write_register(CFG_TAU, COEFF_W'(1));
    write_register(CFG_PRES, COEFF_W'(0));
    write_register(CFG_SAT, COEFF_W'(0));
    send_reading(3'd3, 1'b1, 12'd0, 12'd1, 16'd1);
    settle_block();
    write_register(CFG_PRES, COEFF_W'(4095));
    write_register(CFG_SAT, COEFF_W'(4095));
    send_reading(3'd3, 1'b1, 12'd0, 12'd4095, 16'd1);
    settle_block();
    write_register(CFG_PRES, COEFF_W'(40));
    write_register(CFG_SAT, COEFF_W'(39));
    send_reading(3'd3, 1'b1, 12'd0, 12'd40, 16'd1);
  endtask

  // distance clamps, floored denominator, signed offsets
  task automatic test_distance_coefficients();
    settle_block();
    write_register(CFG_TAU, COEFF_W'(1));
    write_register(CFG_COEFF0 + 3'd0, pack_coeff(32'd0, 16'd0, 16'h8000));
    write_register(CFG_COEFF0 + 3'd1, pack_coeff(32'hFFFF_FFFF, 16'd0, 16'h7FFF));
    write_register(CFG_COEFF0 + 3'd2, pack_coeff(32'd100000, 16'h7FFF, 16'd0));
    write_register(CFG_COEFF0 + 3'd3, pack_coeff(32'hFFFF_FFFF, 16'h8000, 16'd0));
    write_register(CFG_COEFF0 + 3'd4, pack_coeff(32'd1200000000, 16'd20, 16'hB1E0));
    send_reading(3'd0, 1'b1, 12'd0, 12'd500, 16'hFFFF);
    send_reading(3'd1, 1'b1, 12'd0, 12'd1, 16'hFFFF);
    send_reading(3'd2, 1'b1, 12'd0, 12'd3000, 16'hFFFF);
    send_reading(3'd3, 1'b1, 12'd0, 12'd4095, 16'hFFFF);
    send_reading(3'd4, 1'b1, 12'd0, 12'd4000, 16'hFFFF);
  endtask

  // random readings under one idling pattern, new settings every block of items
  task automatic test_random_traffic(input int items, input int s_idle, input int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < items; i++) begin
      if (i % ITEMS_PER_SET == 0) begin
        settle_block();
        randomize_registers();
      end
      send_random_reading();
    end
  endtask

  initial begin
    apply_reset();
    test_sample_extremes();
    test_unfitted_decay();
    test_out_of_range_channels();
    test_time_constant();
    test_thresholds();
    test_distance_coefficients();
    test_random_traffic(RANDOM_ITEMS, 23, 80);
    test_random_traffic(RANDOM_ITEMS, 80, 23);
    test_random_traffic(RANDOM_ITEMS, 0, 0);
    settle_block();
    if (pending_ranges.size() != 0) begin
      $display("%0t %0d results never arrived", $time, pending_ranges.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[ir_range_sensor_conditioner_top] OK");
    end else begin
      $display("[ir_range_sensor_conditioner_top] ERROR");
    end
    $finish;
  end

endmodule

### files.f
design/irc_pkg.sv
design/irc_level_unit.sv
design/irc_dist_unit.sv
design/ir_range_sensor_conditioner_top.sv
dv/tb_top.sv
